@@ src/pic_pkg.sv @@
// Shared types and constants for the priority interrupt controller.
package pic_pkg;

  localparam int NumSourcesDefault = 14;
  localparam int MaxSources        = 15;
  localparam int IdxW              = 4;
  localparam int ByteW             = 8;
  localparam int MaskW             = 16;

  localparam logic [ByteW-1:0] VectorBaseReset = 8'h70;

  localparam logic [1:0] CMD_RAISE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [IdxW-1:0]  source;
    logic             byte_lane;
    logic [ByteW-1:0] write_data;
  } pic_in_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             irq_request;
    logic [ByteW-1:0] irq_vector;
  } pic_out_t;

endpackage

@@ src/pic_if.sv @@
// Valid/ready channel interfaces for bus words and result words.
interface pic_in_if;
  logic             valid;
  logic             ready;
  pic_pkg::pic_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pic_out_if;
  logic              valid;
  logic              ready;
  pic_pkg::pic_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/priority_interrupt_controller_core.sv @@
// Priority interrupt controller: status/in-service registers, lowest-first selection.
//
//  channel   dir  word                                         handshake
//  bus       in   command, source, byte_lane, write_data       valid/ready
//  result    out  read_data, irq_request, irq_vector           valid/ready
//  base_we   in   base_wdata -> vector_base                     write enable only
//
// One word per cycle while result.ready holds; a word passes an input register, then a result register.
// The status update, priority pick and vector add sit between those two registers.
// Synchronous reset clears status, in-service, both valid flags and sets base to 0x70.
// A stalled result holds the input stage; bus.ready drops only when both are full.
module priority_interrupt_controller_core #(
  parameter int NUM_SOURCES = pic_pkg::NumSourcesDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  pic_in_if.sink                   bus,
  pic_out_if.source                result,
  input  logic                     base_we,
  input  logic [pic_pkg::ByteW-1:0] base_wdata
);
  import pic_pkg::*;

  logic                   stage_valid;
  pic_in_t                stage;
  logic                   advance;

  logic [ByteW-1:0]       vector_base;
  logic [NUM_SOURCES-1:0] status_bits;
  logic [NUM_SOURCES-1:0] in_service;
  logic [NUM_SOURCES-1:0] status_bits_next;
  logic [NUM_SOURCES-1:0] in_service_next;
  pic_out_t               word_next;

  assign advance   = stage_valid && (!result.valid || result.ready);
  assign bus.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (bus.ready) begin
      stage_valid <= bus.valid;
    end
    if (bus.valid && bus.ready) begin
      stage <= bus.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_base <= VectorBaseReset;
    end else if (base_we) begin
      vector_base <= base_wdata;
    end
  end

  always_comb begin
    logic [MaskW-1:0]       status_wide;
    logic [MaskW-1:0]       clear_mask;
    logic [NUM_SOURCES-1:0] raise_mask;
    logic [NUM_SOURCES-1:0] status_mid;
    logic [NUM_SOURCES-1:0] service_mid;
    logic [NUM_SOURCES-1:0] lowest;
    logic [IdxW-1:0]        idx;
    logic                   pick;
    logic [ByteW-1:0]       rd;

    status_wide = MaskW'(status_bits);
    clear_mask  = stage.byte_lane ? {stage.write_data, 8'h00} : {8'h00, stage.write_data};
    raise_mask  = ({1'b0, stage.source} < (IdxW + 1)'(NUM_SOURCES))
                  ? (NUM_SOURCES'(1) << stage.source) : '0;
    status_mid  = status_bits;
    service_mid = in_service;
    pick        = 1'b0;
    rd          = '0;

    case (stage.command)
      CMD_RAISE: begin
        status_mid = status_bits | raise_mask;
        pick       = 1'b1;
      end
      CMD_READ: begin
        rd = stage.byte_lane ? status_wide[15:8] : status_wide[7:0];
      end
      CMD_ACK: begin
        // top bit of the shifted mask means "end of service" for the current source
        if (clear_mask[MaskW-1]) begin
          status_mid  = status_bits & ~in_service;
          service_mid = '0;
        end else begin
          status_mid  = status_bits & ~clear_mask[NUM_SOURCES-1:0];
          service_mid = in_service & ~clear_mask[NUM_SOURCES-1:0];
        end
        pick = 1'b1;
      end
      default: begin
      end
    endcase

    // isolate lowest pending bit
    lowest = status_mid & (~status_mid + NUM_SOURCES'(1));
    status_bits_next = status_mid;
    in_service_next  = (pick && (service_mid == '0)) ? lowest : service_mid;

    idx = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (in_service_next[i]) begin
        idx = idx | IdxW'(i);
      end
    end

    word_next.read_data   = rd;
    word_next.irq_request = (in_service_next != '0);
    word_next.irq_vector  = (in_service_next != '0)
                            ? ByteW'(vector_base + ByteW'(idx)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits  <= '0;
      in_service   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        status_bits  <= status_bits_next;
        in_service   <= in_service_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
    if (advance) begin
      result.data <= word_next;
    end
  end

`ifndef SYNTH
  a_service_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(in_service))
    else $error("more than one source in service");

  a_service_pending: assert property (@(posedge clk) disable iff (rst)
    (in_service & ~status_bits) == '0)
    else $error("source in service without pending status");

  a_pick_after_update: assert property (@(posedge clk) disable iff (rst)
    advance && (stage.command == CMD_RAISE || stage.command == CMD_ACK)
    |=> (status_bits == '0) || (in_service != '0))
    else $error("pending status left unserviced");

  a_request_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.data.irq_request == (in_service != '0))
    else $error("irq_request disagrees with in-service state");
`endif

endmodule
